// ===== hdl/text_console_with_escape_attr_top_assert.svh =====
// Assertion macros shared by the console checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef TEXT_CONSOLE_WITH_ESCAPE_ATTR_TOP_ASSERT_SVH
`define TEXT_CONSOLE_WITH_ESCAPE_ATTR_TOP_ASSERT_SVH

// Same-cycle implication, switched off while reset is applied.
`define TCEA_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is applied.
`define TCEA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define TCEA_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/tcea_pkg.sv =====
// Shared constants and types of the text console block.
// No dependencies; used by the parser, the top level and the checker.
package tcea_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam logic [7:0] ATTR_NORMAL = 8'h07;
  localparam logic [7:0] ATTR_BRIGHT = 8'h0f;

  localparam logic [7:0] CH_ESC    = 8'h1b;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_M      = 8'h6d;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // What a put transfer asks the sequencer to do.
  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_PRINT   = 3'd1,
    ACT_NEWLINE = 3'd2,
    ACT_HOME    = 3'd3,
    ACT_TAB     = 3'd4
  } act_t;

  typedef struct packed {
    act_t       act;
    logic [7:0] attr;
  } parse_t;

endpackage

// ===== hdl/tcea_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tcea_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/tcea_esc.sv =====
// Escape sequence parser: tracks ESC [ digits m and decodes each put byte.
// Depends on tcea_pkg.
module tcea_esc
  import tcea_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       put_en,
  input  logic [7:0] char_code,
  output parse_t     dec
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_ESC  = 3'b010,
    PH_CSI  = 3'b100
  } phase_t;

  phase_t phase_r, phase_nxt;
  logic   nz_r, nz_nxt;
  logic   bright_r, bright_nxt;
  logic   plain;

  always_comb begin
    phase_nxt  = phase_r;
    nz_nxt     = nz_r;
    bright_nxt = bright_r;
    plain      = 1'b0;
    dec.act    = ACT_NONE;
    dec.attr   = bright_r ? ATTR_BRIGHT : ATTR_NORMAL;

    case (phase_r)
      PH_ESC: begin
        if (char_code == CH_LBRACK) begin
          phase_nxt = PH_CSI;
        end else begin
          phase_nxt = PH_IDLE;
          plain     = 1'b1;
        end
      end
      PH_CSI: begin
        if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
          if (char_code != CH_ZERO) begin
            nz_nxt = 1'b1;
          end
        end else if (char_code == CH_M) begin
          bright_nxt = nz_r;
          phase_nxt  = PH_IDLE;
        end else begin
          phase_nxt = PH_IDLE;
          plain     = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        plain     = 1'b1;
      end
    endcase

    // A byte outside a sequence, or one that breaks a sequence off, is handled as an ordinary byte.
    if (plain) begin
      if (char_code == CH_NL) begin
        dec.act = ACT_NEWLINE;
      end else if (char_code == CH_CR) begin
        dec.act = ACT_HOME;
      end else if (char_code == CH_TAB) begin
        dec.act = ACT_TAB;
      end else if (char_code == CH_ESC) begin
        phase_nxt = PH_ESC;
        nz_nxt    = 1'b0;
      end else begin
        dec.act = ACT_PRINT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      nz_r     <= 1'b0;
      bright_r <= 1'b0;
    end else if (put_en) begin
      phase_r  <= phase_nxt;
      nz_r     <= nz_nxt;
      bright_r <= bright_nxt;
    end
  end

endmodule

// ===== hdl/text_console_with_escape_attr_top.sv =====
// Text console engine: screen cell RAM, cursor, scroll and read sequencer.
// Depends on tcea_pkg, tcea_esc and tcea_ram.
//
// Usage: in_tuser selects the item kind (0 put a byte, 1 read a cell). A put
// interprets in_tdata's character byte (printable, newline, carriage return,
// tab or an ESC [ n m attribute sequence). A read returns the character and
// attribute of the cell at row/column; row ROWS-1 is the bottom line. Every
// input transfer produces exactly one output transfer carrying the cell
// bytes (zero for a put or an out-of-range read) and the cursor column.
// A put that does not scroll and an out-of-range read give their result in the
// cycle after the input transfer; an in-range read passes through the address
// register, the RAM read and the output register. A scroll (newline, or a print
// past the last column) clears the new bottom row one cell per cycle. Rows live
// in the RAM as a ring, so a scroll moves no data. Simple puts can follow one per
// cycle while the receiver takes each result as it comes.
// Reset: the whole cell RAM is cleared, one cell per cycle, all ROWS*COLUMNS cells
// (2000 by default); in_tready stays low until that pass ends.
// Stalls: the result waits in the output register; a new item is taken
// while it waits only in the cycle in which the receiver takes it.
module text_console_with_escape_attr_top
  import tcea_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF,
  localparam int CW     = $clog2(COLUMNS + 1),
  localparam int RW     = $clog2(ROWS),
  localparam int IN_DW  = ((8 + RW + CW + 7) / 8) * 8,
  localparam int OUT_DW = ((16 + CW + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // char_code, row, column
  input  logic              in_tuser,   // op
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata   // cell_char, cell_attr, cursor_column
);

  localparam int DEPTH = ROWS * COLUMNS;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_RADDR = 4'b0100,
    S_RDATA = 4'b1000
  } st_t;

  st_t             st_r, st_nxt;
  logic [CW-1:0]   cursor_r, cursor_nxt;
  logic [RW-1:0]   bot_r, bot_nxt;
  logic [AW-1:0]   rowbase_r, rowbase_nxt;
  logic [AW-1:0]   clr_addr_r, clr_addr_nxt;
  logic [AW-1:0]   clr_last_r, clr_last_nxt;
  logic            owe_r, owe_nxt;
  logic            pend_r, pend_nxt;
  logic [7:0]      pchar_r, pchar_nxt;
  logic [7:0]      pattr_r, pattr_nxt;
  logic [RW-1:0]   phys_r, phys_nxt;
  logic [CW-1:0]   col_r, col_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_char_r, out_attr_r;
  logic [CW-1:0]   out_cur_r;

  logic            ld;
  logic [7:0]      ld_char, ld_attr;
  logic [CW-1:0]   ld_cur;
  logic            we, re;
  logic [AW-1:0]   waddr, raddr;
  logic [15:0]     wdata, rdata;

  logic            accept, put_en;
  logic [7:0]      in_char;
  logic [RW-1:0]   in_row;
  logic [CW-1:0]   in_col;
  parse_t          dec;

  logic [RW:0]     phys_sum;
  logic [RW-1:0]   phys_calc;
  logic [AW-1:0]   scroll_rb;
  logic [RW-1:0]   scroll_bot;
  logic [CW:0]     tab_sum;
  logic [CW:0]     tab_next;
  logic [CW-1:0]   tab_col;

  assign in_char = in_tdata[7:0];
  assign in_row  = in_tdata[8 +: RW];
  assign in_col  = in_tdata[8 + RW +: CW];

  assign in_tready = (st_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign put_en    = accept && !in_tuser;

  tcea_esc u_esc (
    .clk       (clk),
    .rst_n     (rst_n),
    .put_en    (put_en),
    .char_code (in_char),
    .dec       (dec)
  );

  tcea_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Logical row r sits at ring row (bottom + 1 + r) mod ROWS.
  assign phys_sum  = (RW + 1)'(bot_r) + (RW + 1)'(1) + (RW + 1)'(in_row);
  assign phys_calc = (phys_sum >= (RW + 1)'(ROWS)) ? RW'(phys_sum - (RW + 1)'(ROWS))
                                                    : RW'(phys_sum);
  assign raddr     = AW'(phys_r) * AW'(COLUMNS) + AW'(col_r);

  // On a scroll the old top ring row becomes the new bottom row.
  assign scroll_bot = (bot_r == RW'(ROWS - 1)) ? '0 : bot_r + RW'(1);
  assign scroll_rb  = (bot_r == RW'(ROWS - 1)) ? '0 : rowbase_r + AW'(COLUMNS);

  assign tab_sum  = (CW + 1)'(cursor_r) + (CW + 1)'(8);
  assign tab_next = tab_sum & ~(CW + 1)'(7);
  assign tab_col  = (tab_next > (CW + 1)'(COLUMNS)) ? CW'(COLUMNS) : CW'(tab_next);

  always_comb begin
    st_nxt       = st_r;
    cursor_nxt   = cursor_r;
    bot_nxt      = bot_r;
    rowbase_nxt  = rowbase_r;
    clr_addr_nxt = clr_addr_r;
    clr_last_nxt = clr_last_r;
    owe_nxt      = owe_r;
    pend_nxt     = pend_r;
    pchar_nxt    = pchar_r;
    pattr_nxt    = pattr_r;
    phys_nxt     = phys_r;
    col_nxt      = col_r;
    we           = 1'b0;
    waddr        = rowbase_r + AW'(cursor_r);
    wdata        = '0;
    re           = 1'b0;
    ld           = 1'b0;
    ld_char      = '0;
    ld_attr      = '0;
    ld_cur       = cursor_r;

    case (st_r)
      S_CLEAR: begin
        // A print that forced the scroll lands in column 0 during the sweep.
        we    = 1'b1;
        waddr = clr_addr_r;
        if (pend_r && clr_addr_r == rowbase_r) begin
          wdata = {pattr_r, pchar_r};
        end
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == clr_last_r) begin
          st_nxt   = S_IDLE;
          pend_nxt = 1'b0;
          owe_nxt  = 1'b0;
          if (owe_r) begin
            cursor_nxt = pend_r ? CW'(1) : '0;
            ld         = 1'b1;
            ld_cur     = cursor_nxt;
          end
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_tuser) begin
            if ((RW + 1)'(in_row) < (RW + 1)'(ROWS) && in_col < CW'(COLUMNS)) begin
              phys_nxt = phys_calc;
              col_nxt  = in_col;
              st_nxt   = S_RADDR;
            end else begin
              ld = 1'b1;
            end
          end else begin
            case (dec.act)
              ACT_PRINT: begin
                if (cursor_r >= CW'(COLUMNS)) begin
                  bot_nxt      = scroll_bot;
                  rowbase_nxt  = scroll_rb;
                  clr_addr_nxt = scroll_rb;
                  clr_last_nxt = scroll_rb + AW'(COLUMNS - 1);
                  pend_nxt     = 1'b1;
                  pchar_nxt    = in_char;
                  pattr_nxt    = dec.attr;
                  owe_nxt      = 1'b1;
                  st_nxt       = S_CLEAR;
                end else begin
                  we         = 1'b1;
                  wdata      = {dec.attr, in_char};
                  cursor_nxt = cursor_r + CW'(1);
                  ld         = 1'b1;
                  ld_cur     = cursor_nxt;
                end
              end
              ACT_NEWLINE: begin
                bot_nxt      = scroll_bot;
                rowbase_nxt  = scroll_rb;
                clr_addr_nxt = scroll_rb;
                clr_last_nxt = scroll_rb + AW'(COLUMNS - 1);
                pend_nxt     = 1'b0;
                owe_nxt      = 1'b1;
                st_nxt       = S_CLEAR;
              end
              ACT_HOME: begin
                cursor_nxt = '0;
                ld         = 1'b1;
                ld_cur     = '0;
              end
              ACT_TAB: begin
                cursor_nxt = tab_col;
                ld         = 1'b1;
                ld_cur     = tab_col;
              end
              default: begin
                ld = 1'b1;
              end
            endcase
          end
        end
      end
      S_RADDR: begin
        re     = 1'b1;
        st_nxt = S_RDATA;
      end
      S_RDATA: begin
        ld      = 1'b1;
        ld_char = rdata[7:0];
        ld_attr = rdata[15:8];
        st_nxt  = S_IDLE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = ld ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLEAR;
      cursor_r    <= '0;
      bot_r       <= RW'(ROWS - 1);
      rowbase_r   <= AW'((ROWS - 1) * COLUMNS);
      clr_addr_r  <= '0;
      clr_last_r  <= AW'(DEPTH - 1);
      owe_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cursor_r    <= cursor_nxt;
      bot_r       <= bot_nxt;
      rowbase_r   <= rowbase_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_last_r  <= clr_last_nxt;
      owe_r       <= owe_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pchar_r <= pchar_nxt;
    pattr_r <= pattr_nxt;
    phys_r  <= phys_nxt;
    col_r   <= col_nxt;
    if (ld) begin
      out_char_r <= ld_char;
      out_attr_r <= ld_attr;
      out_cur_r  <= ld_cur;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'({out_cur_r, out_attr_r, out_char_r});

endmodule

// ===== hdl/tcea_chk.sv =====
// Port-level checker for the text console top level, bound to every instance.
// Depends on tcea_pkg and text_console_with_escape_attr_top_assert.svh.
`include "text_console_with_escape_attr_top_assert.svh"

module tcea_chk
  import tcea_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF,
  localparam int CW     = $clog2(COLUMNS + 1),
  localparam int RW     = $clog2(ROWS),
  localparam int IN_DW  = ((8 + RW + CW + 7) / 8) * 8,
  localparam int OUT_DW = ((16 + CW + 7) / 8) * 8
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [IN_DW-1:0]  in_tdata,
  input logic              in_tuser,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata
);

  logic in_xfer, bad_read;

  assign in_xfer  = in_tvalid && in_tready;
  assign bad_read = in_tuser && ((RW + 1)'(in_tdata[8 +: RW]) >= (RW + 1)'(ROWS) ||
                                 in_tdata[8 + RW +: CW] >= CW'(COLUMNS));

  // The result register must hold still while the receiver stalls.
  `TCEA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
                    out_tvalid && $stable(out_tdata), "stalled result changed")

  // A new item is taken only when its result has room to land.
  `TCEA_ASSERT(a_room, in_tready, !out_tvalid || out_tready,
               "input taken while output register is full")

  // The clearing pass after reset keeps the input closed.
  `TCEA_ASSERT_RST(a_reset_closed, !rst_n, !in_tready,
                   "input open right after reset")

  // A read outside the screen answers next cycle with empty cell bytes.
  `TCEA_ASSERT_NEXT(a_bad_read, in_xfer && bad_read,
                    out_tvalid && out_tdata[15:0] == 16'd0, "out-of-range read not zero")

  // The cursor never goes past the column count.
  `TCEA_ASSERT(a_cursor, out_tvalid, out_tdata[16 +: CW] <= CW'(COLUMNS),
               "cursor beyond last column")

endmodule

bind text_console_with_escape_attr_top tcea_chk #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcea_chk (.*);

// ===== tb/sv/tb_text_console_with_escape_attr_top.sv =====
// Self-checking bench for the text console block: puts, escape sequences and cell reads.
// Depends on tcea_pkg and text_console_with_escape_attr_top; a local screen copy predicts
// each result a directed item does not fix, and a directed list precedes a random phase.
module tb_text_console_with_escape_attr_top;
  import tcea_pkg::*;

  localparam int COLS      = COLUMNS_DEF;
  localparam int LINES     = ROWS_DEF;
  localparam int IN_W      = 24;
  localparam int OUT_W     = 24;
  localparam int IDLE_MAX  = 8000;
  localparam int RAND_ITEMS = 400;

  typedef enum logic {OP_PUT = 1'b0, OP_READ = 1'b1} op_t;
  typedef enum logic [1:0] {ESC_IDLE, ESC_AFTER_ESC, ESC_IN_CSI} esc_phase_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic [6:0] cursor;
  } cell_report_t;

  typedef struct {
    op_t          op;
    logic [7:0]   ch;
    logic [4:0]   r;
    logic [6:0]   c;
    bit           typed;
    cell_report_t known;
  } stim_item_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             in_tuser = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  text_console_with_escape_attr_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Shadow copy of the console state.
  logic [15:0]  shadow_screen [LINES*COLS];
  int           shadow_cursor = 0;
  esc_phase_t   shadow_phase = ESC_IDLE;
  bit           shadow_nonzero = 1'b0;
  bit           shadow_bright = 1'b0;

  cell_report_t pending_reports [$];
  stim_item_t   directed_items [$];

  int errors = 0;
  int results_seen = 0;
  int items_sent = 0;
  int put_count = 0;
  int read_count = 0;
  int scroll_count = 0;
  int tab_clamp_count = 0;
  int bright_prints = 0;
  int off_screen_reads = 0;
  int idle_cycles = 0;
  bit sender_calm = 1'b0;
  bit receiver_calm = 1'b0;

  initial begin
    for (int i = 0; i < LINES*COLS; i++) shadow_screen[i] = '0;
  end

  function automatic void scroll_screen();
    for (int i = 0; i < (LINES-1)*COLS; i++) shadow_screen[i] = shadow_screen[i+COLS];
    for (int i = (LINES-1)*COLS; i < LINES*COLS; i++) shadow_screen[i] = '0;
    scroll_count++;
  endfunction

  // Applies one item to the shadow state and returns the report the block must give.
  function automatic cell_report_t console_step(op_t op, logic [7:0] ch, logic [4:0] r,
                                                logic [6:0] c);
    cell_report_t rep;
    bit           plain;
    int           nxt;
    logic [7:0]   attr;
    rep = '0;
    plain = 1'b1;
    if (op == OP_READ) begin
      read_count++;
      if (r < LINES && c < COLS) begin
        rep.cell_char = shadow_screen[r*COLS + c][7:0];
        rep.cell_attr = shadow_screen[r*COLS + c][15:8];
      end else begin
        off_screen_reads++;
      end
    end else begin
      put_count++;
      case (shadow_phase)
        ESC_AFTER_ESC: begin
          if (ch == CH_LBRACK) begin
            shadow_phase = ESC_IN_CSI;
            plain = 1'b0;
          end else begin
            shadow_phase = ESC_IDLE;
          end
        end
        ESC_IN_CSI: begin
          if (ch >= CH_ZERO && ch <= CH_NINE) begin
            if (ch != CH_ZERO) shadow_nonzero = 1'b1;
            plain = 1'b0;
          end else if (ch == CH_M) begin
            shadow_bright = shadow_nonzero;
            shadow_phase = ESC_IDLE;
            plain = 1'b0;
          end else begin
            shadow_phase = ESC_IDLE;
          end
        end
        default: shadow_phase = ESC_IDLE;
      endcase
      if (plain) begin
        if (ch == CH_NL) begin
          scroll_screen();
          shadow_cursor = 0;
        end else if (ch == CH_CR) begin
          shadow_cursor = 0;
        end else if (ch == CH_TAB) begin
          nxt = (shadow_cursor + 8) & ~7;
          if (nxt >= COLS) tab_clamp_count++;
          shadow_cursor = (nxt > COLS) ? COLS : nxt;
        end else if (ch == CH_ESC) begin
          shadow_phase = ESC_AFTER_ESC;
          shadow_nonzero = 1'b0;
        end else begin
          attr = shadow_bright ? ATTR_BRIGHT : ATTR_NORMAL;
          if (shadow_bright) bright_prints++;
          if (shadow_cursor >= COLS) begin
            scroll_screen();
            shadow_cursor = 0;
          end
          shadow_screen[(LINES-1)*COLS + shadow_cursor] = {attr, ch};
          shadow_cursor++;
        end
      end
    end
    rep.cursor = shadow_cursor[6:0];
    return rep;
  endfunction

  function automatic int draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  // One input transfer; valid stays high between back-to-back items.
  task automatic send_item(op_t op, logic [7:0] ch, logic [4:0] r, logic [6:0] c,
                           bit typed, cell_report_t known);
    int           gap;
    cell_report_t pred;
    if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
    gap = draw_wait(sender_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, c, r, ch};
    do @(posedge clk); while (!in_tready);
    pred = console_step(op, ch, r, c);
    pending_reports.push_back(typed ? known : pred);
    items_sent++;
  endtask

  task automatic put_char(logic [7:0] ch);
    send_item(OP_PUT, ch, 5'($urandom), 7'($urandom), 1'b0, '0);
  endtask

  task automatic read_at(logic [4:0] r, logic [6:0] c);
    send_item(OP_READ, 8'($urandom), r, c, 1'b0, '0);
  endtask

  // Lets every outstanding result drain before the next item.
  task automatic drain_hold();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  function automatic stim_item_t dir_item(op_t op, logic [7:0] ch, logic [4:0] r,
                                          logic [6:0] c, bit typed,
                                          logic [7:0] kc, logic [7:0] ka, logic [6:0] kcur);
    stim_item_t it;
    it.op = op;
    it.ch = ch;
    it.r = r;
    it.c = c;
    it.typed = typed;
    it.known = '{cell_char: kc, cell_attr: ka, cursor: kcur};
    return it;
  endfunction

  // Result checker.
  always @(posedge clk) begin
    cell_report_t got;
    cell_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{cell_char: out_tdata[7:0], cell_attr: out_tdata[15:8],
              cursor: out_tdata[22:16]};
      results_seen++;
      if (pending_reports.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result with nothing pending: char=%h attr=%h cursor=%0d",
                   got.cell_char, got.cell_attr, got.cursor);
      end else begin
        want = pending_reports.pop_front();
        if (got != want) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: result %0d: char %h/%h attr %h/%h cursor %0d/%0d (exp/got)",
                     results_seen, want.cell_char, got.cell_char, want.cell_attr,
                     got.cell_attr, want.cursor, got.cursor);
        end
      end
    end
  end

  // Receiver: random stalls between transfers, with calm stretches.
  initial begin
    int stall;
    wait (rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) receiver_calm = !receiver_calm;
      stall = draw_wait(receiver_calm);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Watchdog on cycles without any transfer; covers the clearing pass after reset.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_MAX) begin
      $display("ERROR: no transfer for %0d cycles", IDLE_MAX);
      $display("tb_text_console_with_escape_attr_top NOT OK");
      $finish;
    end
  end

  initial begin
    int          kind;
    int          len;
    logic [4:0]  r;
    logic [6:0]  c;
    stim_item_t  it;

    // Directed items: extremes, the attribute sequence and each way it can break.
    directed_items.push_back(dir_item(OP_READ, 8'h00, 5'd0, 7'd0, 1, 8'h00, 8'h00, 7'd0));
    directed_items.push_back(dir_item(OP_READ, 8'hff, 5'd31, 7'd127, 1, 8'h00, 8'h00, 7'd0));
    directed_items.push_back(dir_item(OP_PUT, 8'h41, 5'd0, 7'd0, 1, 8'h00, 8'h00, 7'd1));
    directed_items.push_back(dir_item(OP_READ, 8'h00, 5'd24, 7'd0, 1, 8'h41, ATTR_NORMAL,
                                      7'd1));
    directed_items.push_back(dir_item(OP_PUT, CH_ESC, 5'd31, 7'd127, 0, 0, 0, 0));
    directed_items.push_back(dir_item(OP_PUT, CH_LBRACK, 5'd0, 7'd0, 0, 0, 0, 0));
    directed_items.push_back(dir_item(OP_PUT, CH_ZERO, 5'd0, 7'd0, 0, 0, 0, 0));
    directed_items.push_back(dir_item(OP_PUT, CH_ZERO + 8'd5, 5'd0, 7'd0, 0, 0, 0, 0));
    directed_items.push_back(dir_item(OP_PUT, CH_M, 5'd0, 7'd0, 0, 0, 0, 0));
    directed_items.push_back(dir_item(OP_PUT, 8'hff, 5'd0, 7'd0, 0, 0, 0, 0));
    directed_items.push_back(dir_item(OP_READ, 8'h00, 5'd24, 7'd1, 1, 8'hff, ATTR_BRIGHT,
                                      7'd2));
    // A byte after ESC that is not a bracket gets printed.
    directed_items.push_back(dir_item(OP_PUT, CH_ESC, 5'd0, 7'd0, 0, 0, 0, 0));
    directed_items.push_back(dir_item(OP_PUT, 8'h78, 5'd0, 7'd0, 0, 0, 0, 0));
    // A newline inside the bracket part cancels it and still scrolls.
    directed_items.push_back(dir_item(OP_PUT, CH_ESC, 5'd0, 7'd0, 0, 0, 0, 0));
    directed_items.push_back(dir_item(OP_PUT, CH_LBRACK, 5'd0, 7'd0, 0, 0, 0, 0));
    directed_items.push_back(dir_item(OP_PUT, CH_ZERO + 8'd1, 5'd0, 7'd0, 0, 0, 0, 0));
    directed_items.push_back(dir_item(OP_PUT, CH_NL, 5'd0, 7'd0, 0, 0, 0, 0));
    // No digits at all selects the normal attribute.
    directed_items.push_back(dir_item(OP_PUT, CH_ESC, 5'd0, 7'd0, 0, 0, 0, 0));
    directed_items.push_back(dir_item(OP_PUT, CH_LBRACK, 5'd0, 7'd0, 0, 0, 0, 0));
    directed_items.push_back(dir_item(OP_PUT, CH_M, 5'd0, 7'd0, 0, 0, 0, 0));
    directed_items.push_back(dir_item(OP_PUT, CH_TAB, 5'd0, 7'd0, 0, 0, 0, 0));
    directed_items.push_back(dir_item(OP_PUT, CH_CR, 5'd0, 7'd0, 0, 0, 0, 0));
    directed_items.push_back(dir_item(OP_PUT, 8'h00, 5'd0, 7'd0, 0, 0, 0, 0));
    directed_items.push_back(dir_item(OP_READ, 8'h00, 5'd23, 7'd0, 0, 0, 0, 0));
    directed_items.push_back(dir_item(OP_READ, 8'h00, 5'd24, 7'd79, 0, 0, 0, 0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_items[i]) begin
      it = directed_items[i];
      send_item(it.op, it.ch, it.r, it.c, it.typed, it.known);
    end
    drain_hold();

    // Random bursts, mostly well-formed text and sequences, some noise.
    while (items_sent < directed_items.size() + RAND_ITEMS) begin
      if ($urandom_range(0, 39) == 0) drain_hold();
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 90) : $urandom_range(1, 8);
        repeat (len) begin
          if ($urandom_range(0, 7) == 0) put_char(8'($urandom));
          else put_char(8'($urandom_range(8'h20, 8'h7e)));
        end
      end else if (kind < 45) begin
        put_char(CH_ESC);
        put_char(CH_LBRACK);
        len = $urandom_range(0, 3);
        if ($urandom_range(0, 1) == 0) begin
          repeat (len) put_char(CH_ZERO);
        end else begin
          repeat (len) put_char(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        put_char(CH_M);
      end else if (kind < 53) begin
        put_char(CH_ESC);
        if ($urandom_range(0, 1) == 0) begin
          put_char(CH_LBRACK);
          repeat ($urandom_range(0, 2)) put_char(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        put_char(8'($urandom));
      end else if (kind < 60) begin
        repeat ($urandom_range(1, 12)) put_char(CH_TAB);
      end else if (kind < 65) begin
        put_char(CH_NL);
      end else if (kind < 68) begin
        put_char(CH_CR);
      end else if (kind < 90) begin
        if ($urandom_range(0, 3) != 0) begin
          r = ($urandom_range(0, 1) == 0) ? 5'($urandom_range(20, 24))
                                           : 5'($urandom_range(0, 24));
          c = 7'($urandom_range(0, 79));
        end else begin
          r = 5'($urandom);
          c = 7'($urandom);
        end
        read_at(r, c);
      end else begin
        send_item(op_t'($urandom_range(0, 1)), 8'($urandom), 5'($urandom), 7'($urandom),
                  1'b0, '0);
      end
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
    repeat (COLS + 10) @(posedge clk);

    $display("Covered %0d items (%0d puts, %0d reads, %0d off-screen), %0d results checked.",
             items_sent, put_count, read_count, off_screen_reads, results_seen);
    $display("Saw %0d scrolls, %0d tabs at the line end, %0d bright prints, %0d errors.",
             scroll_count, tab_clamp_count, bright_prints, errors);
    if (errors == 0) begin
      $display("tb_text_console_with_escape_attr_top OK");
    end else begin
      $display("tb_text_console_with_escape_attr_top NOT OK");
    end
    $finish;
  end

endmodule
